FILE: rtl/amf_pkg.sv
package amf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_RADIUS  = 3;
   localparam int STORE_DEPTH = (2 * MAX_RADIUS + 3) * MAX_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int WID_W       = 11;
   localparam int HGT_W       = 13;
   localparam int RAD_W       = 2;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAX_RADIUS   = 2'd2;

   typedef struct packed {
      logic [WID_W-1:0] w;
      logic [HGT_W-1:0] h;
      logic [RAD_W-1:0] rmax;
   } geom_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] addr;
      logic              eof;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef enum logic [3:0] {
      B_IDLE, B_CENTER, B_RADIUS, B_ROWSTEP, B_SCAN, B_DRAIN, B_PASS, B_EVAL, B_DONE
   } back_state_type;

   function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + 1'b1;
      if (s >= (ADDR_W+1)'(STORE_DEPTH)) s = '0;
      return s[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/amf_queue.sv
module amf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  amf_pkg::job_type  push_job,
   input  logic              pop,
   output amf_pkg::job_type  head,
   output logic              empty,
   output logic              full
);
   import amf_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
endmodule

FILE: rtl/amf_front.sv
module amf_front (
   input  logic              clock,
   input  logic              reset,
   input  amf_pkg::geom_type geom,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_pixel_in,
   input  logic              req_flush,
   input  logic              q_full,
   output logic              q_push,
   output amf_pkg::job_type  q_job,
   input  logic              eof_done,
   output amf_pkg::wr_type   wr
);
   import amf_pkg::*;

   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [ADDR_W-1:0] in_addr_ff, in_addr_in, out_addr_ff, out_addr_in;
   logic              in_full_ff, in_full_in, eof_pend_ff, eof_pend_in;
   logic              acc, due, last;
   logic [HGT_W-1:0]  trow, rsum;
   logic [WID_W-1:0]  tcol, csum;

   assign req_ready = !q_full && !eof_pend_ff;
   assign acc       = req_valid && req_ready;

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_addr_in  = in_addr_ff;
      in_full_in  = in_full_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_addr_in = out_addr_ff;
      eof_pend_in = eof_pend_ff && !eof_done;
      wr.en       = acc && !req_flush && !in_full_ff;
      wr.addr     = in_addr_ff;
      wr.data     = req_pixel_in;

      if (wr.en) begin
         in_addr_in = addr_inc(in_addr_ff);
         if ({1'b0, in_col_ff} + 1'b1 >= geom.w) begin
            in_col_in = '0;
            if ({1'b0, in_row_ff} + 1'b1 >= geom.h) begin
               in_row_in  = '0;
               in_full_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      // Last input position that the largest window of the next output needs.
      rsum = {1'b0, out_row_ff} + HGT_W'(geom.rmax);
      trow = (rsum > geom.h - 1'b1) ? geom.h - 1'b1 : rsum;
      csum = {1'b0, out_col_ff} + WID_W'(geom.rmax);
      tcol = (csum > geom.w - 1'b1) ? geom.w - 1'b1 : csum;
      due  = acc && (in_full_in || {1'b0, in_row_in} > trow ||
             ({1'b0, in_row_in} == trow && {1'b0, in_col_in} > tcol));
      last = ({1'b0, out_col_ff} + 1'b1 >= geom.w) &&
             ({1'b0, out_row_ff} + 1'b1 >= geom.h);

      q_push    = due;
      q_job.row = out_row_ff;
      q_job.col = out_col_ff;
      q_job.addr = out_addr_ff;
      q_job.eof = last;

      if (due) begin
         out_addr_in = addr_inc(out_addr_ff);
         if ({1'b0, out_col_ff} + 1'b1 >= geom.w) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
         if (last) begin
            out_row_in  = '0;
            out_addr_in = '0;
            in_col_in   = '0;
            in_row_in   = '0;
            in_addr_in  = '0;
            in_full_in  = 1'b0;
            eof_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_addr_ff  <= '0;
         in_full_ff  <= 1'b0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_addr_ff <= '0;
         eof_pend_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_addr_ff  <= in_addr_in;
         in_full_ff  <= in_full_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_addr_ff <= out_addr_in;
         eof_pend_ff <= eof_pend_in;
      end
   end
endmodule

FILE: rtl/amf_back.sv
module amf_back (
   input  logic              clock,
   input  logic              reset,
   input  amf_pkg::geom_type geom,
   input  amf_pkg::wr_type   wr,
   input  logic              q_empty,
   input  amf_pkg::job_type  q_head,
   output logic              q_pop,
   output logic              eof_done,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_pixel_out,
   output logic              rsp_end_of_frame
);
   import amf_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   back_state_type state_ff, state_in;
   job_type           job_ff, job_in;
   logic [7:0]        z_ff, z_in, med_ff, med_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [7:0]        res_ff, res_in, trial;
   logic [RAD_W-1:0]  rad_ff, rad_in, steps_ff, steps_in;
   logic [2:0]        bit_ff, bit_in;
   logic [5:0]        lt_ff, lt_in, cnt;
   logic [ROW_W-1:0]  r0_ff, r0_in, r1_ff, r1_in, sr_ff, sr_in;
   logic [COL_W-1:0]  c0_ff, c0_in, c1_ff, c1_in, sc_ff, sc_in;
   logic [ADDR_W-1:0] rb_ff, rb_in, rb0_ff, rb0_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_valid_ff, rsp_valid_in, eof_ff, eof_in;
   logic [HGT_W-1:0]  rs;
   logic [WID_W-1:0]  cs;
   logic [ADDR_W:0]   asum;
   logic [2:0]        rspan, cspan;

   function automatic logic [ADDR_W-1:0] sub_wrap(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (a < b) d = d + (ADDR_W+1)'(STORE_DEPTH);
      return d[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] add_wrap(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ADDR_W+1)'(STORE_DEPTH)) s = s - (ADDR_W+1)'(STORE_DEPTH);
      return s[ADDR_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      rd_data_ff <= mem[rd_addr];
   end

   assign trial = med_ff | (8'd1 << bit_ff);
   assign rspan = 3'(r1_ff - r0_ff) + 3'd1;
   assign cspan = 3'(c1_ff - c0_ff) + 3'd1;
   assign cnt   = {3'b000, rspan} * {3'b000, cspan};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      z_in         = z_ff;
      med_in       = med_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      rad_in       = rad_ff;
      steps_in     = steps_ff;
      bit_in       = bit_ff;
      lt_in        = lt_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      rb_in        = rb_ff;
      rb0_in       = rb0_ff;
      rd_vld_in    = 1'b0;
      rd_addr      = job_ff.addr;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      eof_in       = eof_ff;
      q_pop        = 1'b0;
      eof_done     = 1'b0;
      rs           = '0;
      cs           = '0;
      asum         = '0;

      // Count and extremes of the data returned for the previous read.
      if (rd_vld_ff) begin
         if (rd_data_ff < trial) lt_in = lt_ff + 1'b1;
         if (bit_ff == 3'd7) begin
            if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
            if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
         end
      end

      case (state_ff)
         B_IDLE: begin
            rd_addr = q_head.addr;
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               state_in = B_CENTER;
            end
         end
         B_CENTER: begin
            z_in = rd_data_ff;
            if (geom.rmax == '0) begin
               res_in   = rd_data_ff;
               state_in = B_DONE;
            end else begin
               rad_in   = RAD_W'(1);
               state_in = B_RADIUS;
            end
         end
         B_RADIUS: begin
            r0_in = (job_ff.row >= ROW_W'(rad_ff)) ? job_ff.row - ROW_W'(rad_ff) : '0;
            rs    = {1'b0, job_ff.row} + HGT_W'(rad_ff);
            r1_in = (rs > geom.h - 1'b1) ? ROW_W'(geom.h - 1'b1) : rs[ROW_W-1:0];
            c0_in = (job_ff.col >= COL_W'(rad_ff)) ? job_ff.col - COL_W'(rad_ff) : '0;
            cs    = {1'b0, job_ff.col} + WID_W'(rad_ff);
            c1_in = (cs > geom.w - 1'b1) ? COL_W'(geom.w - 1'b1) : cs[COL_W-1:0];
            steps_in = RAD_W'(job_ff.row - r0_in);
            rb_in    = sub_wrap(job_ff.addr, ADDR_W'(job_ff.col));
            state_in = B_ROWSTEP;
         end
         B_ROWSTEP: begin
            if (steps_ff == '0) begin
               rb0_in   = rb_ff;
               sr_in    = r0_ff;
               sc_in    = c0_ff;
               med_in   = '0;
               bit_in   = 3'd7;
               lt_in    = '0;
               lo_in    = 8'hFF;
               hi_in    = 8'h00;
               state_in = B_SCAN;
            end else begin
               rb_in    = sub_wrap(rb_ff, ADDR_W'(geom.w));
               steps_in = steps_ff - 1'b1;
            end
         end
         B_SCAN: begin
            asum      = {1'b0, rb_ff} + (ADDR_W+1)'(sc_ff);
            if (asum >= (ADDR_W+1)'(STORE_DEPTH)) asum = asum - (ADDR_W+1)'(STORE_DEPTH);
            rd_addr   = asum[ADDR_W-1:0];
            rd_vld_in = 1'b1;
            if (sc_ff == c1_ff) begin
               sc_in = c0_ff;
               if (sr_ff == r1_ff) begin
                  state_in = B_DRAIN;
               end else begin
                  sr_in = sr_ff + 1'b1;
                  rb_in = add_wrap(rb_ff, ADDR_W'(geom.w));
               end
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         B_DRAIN: begin
            state_in = B_PASS;
         end
         B_PASS: begin
            // Keep the trial bit when no more than half the window lies below it.
            if (lt_ff <= (cnt >> 1)) med_in = trial;
            if (bit_ff == 3'd0) begin
               state_in = B_EVAL;
            end else begin
               bit_in   = bit_ff - 1'b1;
               lt_in    = '0;
               sr_in    = r0_ff;
               sc_in    = c0_ff;
               rb_in    = rb0_ff;
               state_in = B_SCAN;
            end
         end
         B_EVAL: begin
            if (lo_ff < med_ff && med_ff < hi_ff) begin
               res_in   = (lo_ff < z_ff && z_ff < hi_ff) ? z_ff : med_ff;
               state_in = B_DONE;
            end else if (rad_ff == geom.rmax) begin
               res_in   = med_ff;
               state_in = B_DONE;
            end else begin
               rad_in   = rad_ff + 1'b1;
               state_in = B_RADIUS;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               eof_in       = job_ff.eof;
               eof_done     = job_ff.eof;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      z_ff     <= z_in;
      med_ff   <= med_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      res_ff   <= res_in;
      rad_ff   <= rad_in;
      steps_ff <= steps_in;
      bit_ff   <= bit_in;
      lt_ff    <= lt_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      sr_ff    <= sr_in;
      sc_ff    <= sc_in;
      rb_ff    <= rb_in;
      rb0_ff   <= rb0_in;
      eof_ff   <= eof_in;
   end

   logic [7:0] out_ff;
   always_ff @(posedge clock) begin
      if (state_ff == B_DONE && (!rsp_valid_ff || rsp_ready)) out_ff <= res_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = out_ff;
   assign rsp_end_of_frame = eof_ff;
endmodule

FILE: rtl/adaptive_median_filter.sv
// With max_radius 0, a due position is popped from the queue and its center pixel is
// read and returned as the result; each radius tried adds one window scan per result
// bit and a row step for each window row above the center.
// Throughput: the back end ranks one job at a time with one line store read per
// cycle, which sets the rate; the front takes one item per cycle until the
// two-entry queue is full, and after a frame's last position until that result is out.
// Reset is synchronous and active high; it clears positions, the job queue
// and the output valid flag, and restores the default frame size and radius.
module adaptive_median_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_in,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_end_of_frame,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wr_data
);
   import amf_pkg::*;

   // Configuration registers as written by software.
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_ff;
   geom_type         geom;
   job_type          q_job, q_head;
   wr_type           wr;
   logic             q_push, q_pop, q_empty, q_full, eof_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(1024);
         height_ff <= HGT_W'(768);
         radius_ff <= RAD_W'(3);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wr_data[WID_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wr_data[HGT_W-1:0];
            CSR_MAX_RADIUS:   radius_ff <= csr_wr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero behaves as one; sizes above the store limits are clipped.
   always_comb begin
      geom.w = width_ff;
      if (width_ff == '0) geom.w = WID_W'(1);
      else if (width_ff > WID_W'(MAX_WIDTH)) geom.w = WID_W'(MAX_WIDTH);
      geom.h = height_ff;
      if (height_ff == '0) geom.h = HGT_W'(1);
      else if (height_ff > HGT_W'(MAX_HEIGHT)) geom.h = HGT_W'(MAX_HEIGHT);
      geom.rmax = radius_ff;
   end

   // The front end writes pixels into the store and decides when an output position is due.
   amf_front u_front (
      .clock, .reset, .geom,
      .req_valid, .req_ready, .req_pixel_in, .req_flush,
      .q_full, .q_push, .q_job, .eof_done, .wr
   );

   // Short queue of due output positions between the two halves.
   amf_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_job(q_job), .pop(q_pop),
      .head(q_head), .empty(q_empty), .full(q_full)
   );

   // The back end owns the line store and ranks each window.
   amf_back u_back (
      .clock, .reset, .geom, .wr,
      .q_empty, .q_head, .q_pop, .eof_done,
      .rsp_valid, .rsp_ready, .rsp_pixel_out, .rsp_end_of_frame
   );
endmodule

FILE: rtl/amf_checker.sv
module amf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_out,
   input logic       rsp_end_of_frame
);
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out) && $stable(rsp_end_of_frame))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind adaptive_median_filter amf_checker u_amf_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_pixel_out, .rsp_end_of_frame
);
